/* hdl/pqrs_pkg.sv */
// ----------------------------------------------------------------------------
// pqrs_pkg
// Types and constants shared by the piece queue with reserve stack.
// ----------------------------------------------------------------------------
`default_nettype none

package pqrs_pkg;

    localparam int KIND_BITS   = 2;
    localparam int TAG_W       = 16;
    localparam int MULTI_SWAP  = 3;

    localparam logic [2:0] CMD_PLAY    = 3'd0;
    localparam logic [2:0] CMD_RESERVE = 3'd1;
    localparam logic [2:0] CMD_USE     = 3'd2;
    localparam logic [2:0] CMD_SWAP    = 3'd3;
    localparam logic [2:0] CMD_SWAP3   = 3'd4;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [1:0] ST_TOO_FEW    = 2'd3;

    typedef struct packed {
        logic [2:0]           command;
        logic [KIND_BITS-1:0] new_kind;
        logic [TAG_W-1:0]     new_tag;
    } t_in_word;

    typedef struct packed {
        logic                 item_valid;
        logic [KIND_BITS-1:0] item_kind;
        logic [TAG_W-1:0]     item_tag;
        logic [1:0]           status;
    } t_out_word;

    typedef struct packed {
        logic       q_pop;
        logic       q_push;
        logic       s_push;
        logic       s_pop;
        logic       swap1;
        logic       swap3;
        logic       out_valid;
        logic       out_from_stack;
        logic [1:0] status;
    } t_ctl;

endpackage

`default_nettype wire

/* hdl/piece_queue_with_reserve_stack.sv */
// ----------------------------------------------------------------------------
// piece_queue_with_reserve_stack
// Throughput: 1 word per cycle unless the output stalls; every command, swap
// three included, finishes in the single step between the input register
// and the result register.
// Reset: synchronous, active low; queue and stack become empty, both word
// registers empty. Stored items are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module piece_queue_with_reserve_stack #(
    parameter int QUEUE_DEPTH = 5,
    parameter int STACK_DEPTH = 3,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pqrs_pkg::t_in_word   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pqrs_pkg::t_out_word       o_out_data
);

    localparam int ITEM_BITS = TAG_BITS + pqrs_pkg::KIND_BITS;
    localparam int NS        = pqrs_pkg::MULTI_SWAP;
    localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW       = $clog2(STACK_DEPTH + 1);

    logic                          r_in_valid;
    pqrs_pkg::t_in_word            r_in;
    logic                          r_out_valid;
    pqrs_pkg::t_out_word           r_out;
    pqrs_pkg::t_out_word           n_out;
    logic                          adv;
    logic                          in_take;
    pqrs_pkg::t_ctl                ctl;
    logic [QCW-1:0]                q_count;
    logic [SCW-1:0]                s_count;
    logic [NS-1:0][ITEM_BITS-1:0]  q_front;
    logic [NS-1:0][ITEM_BITS-1:0]  s_top;
    logic [ITEM_BITS-1:0]          fresh;
    logic [ITEM_BITS-1:0]          gone;
    logic [31:0]                   in_tag_ext;
    logic [31:0]                   out_tag_ext;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    pqrs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_go      (adv),
        .i_command (r_in.command),
        .i_q_count (q_count),
        .i_s_count (s_count),
        .o_ctl     (ctl)
    );

    assign in_tag_ext = 32'(r_in.new_tag);
    assign fresh      = {r_in.new_kind, in_tag_ext[TAG_BITS-1:0]};

    pqrs_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_fresh   (fresh),
        .i_swap_in (s_top),
        .o_front   (q_front),
        .o_count   (q_count)
    );

    pqrs_stack #(
        .DEPTH     (STACK_DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_push_item (q_front[0]),
        .i_swap_in   (q_front),
        .o_top       (s_top),
        .o_count     (s_count)
    );

    assign gone        = ctl.out_from_stack ? s_top[0] : q_front[0];
    assign out_tag_ext = 32'(gone[TAG_BITS-1:0]);

    always_comb begin
        n_out            = '0;
        n_out.status     = ctl.status;
        n_out.item_valid = ctl.out_valid;
        if (ctl.out_valid) begin
            n_out.item_kind = gone[ITEM_BITS-1 -: pqrs_pkg::KIND_BITS];
            n_out.item_tag  = out_tag_ext[pqrs_pkg::TAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_s_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_count <= SCW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_valid) |-> (o_out_data.status == pqrs_pkg::ST_DONE))
        else $error("item returned with error status");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.item_valid)
            |-> (o_out_data.item_kind == '0 && o_out_data.item_tag == '0))
        else $error("nonzero item fields without item");

    a_use_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.command == pqrs_pkg::CMD_USE && s_count != '0)
            |=> (s_count == $past(s_count) - SCW'(1)))
        else $error("use did not pop stack");
`endif

endmodule

`default_nettype wire

/* hdl/pqrs_ctrl.sv */
// ----------------------------------------------------------------------------
// pqrs_ctrl
// Command decode: checks occupancy and issues queue and stack operations.
// ----------------------------------------------------------------------------
`default_nettype none

module pqrs_ctrl #(
    parameter int QUEUE_DEPTH = 5,
    parameter int STACK_DEPTH = 3
) (
    input  wire logic                               i_go,
    input  wire logic [2:0]                         i_command,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_q_count,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0]   i_s_count,
    output pqrs_pkg::t_ctl                          o_ctl
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    logic q_empty;
    logic s_empty;
    logic s_full;
    logic q_few;
    logic s_few;

    assign q_empty = (i_q_count == '0);
    assign s_empty = (i_s_count == '0);
    assign s_full  = (i_s_count == SCW'(STACK_DEPTH));
    assign q_few   = (i_q_count < QCW'(pqrs_pkg::MULTI_SWAP));
    assign s_few   = (i_s_count < SCW'(pqrs_pkg::MULTI_SWAP));

    always_comb begin
        o_ctl        = '0;
        o_ctl.status = pqrs_pkg::ST_DONE;
        case (i_command)
            pqrs_pkg::CMD_PLAY: begin
                o_ctl.q_push = i_go;
                if (q_empty) begin
                    o_ctl.status = pqrs_pkg::ST_EMPTY;
                end else begin
                    o_ctl.q_pop     = i_go;
                    o_ctl.out_valid = 1'b1;
                end
            end
            pqrs_pkg::CMD_RESERVE: begin
                if (s_full) begin
                    o_ctl.status = pqrs_pkg::ST_STACK_FULL;
                end else if (q_empty) begin
                    o_ctl.status = pqrs_pkg::ST_EMPTY;
                end else begin
                    o_ctl.q_pop  = i_go;
                    o_ctl.q_push = i_go;
                    o_ctl.s_push = i_go;
                end
            end
            pqrs_pkg::CMD_USE: begin
                if (s_empty) begin
                    o_ctl.status = pqrs_pkg::ST_EMPTY;
                end else begin
                    o_ctl.s_pop          = i_go;
                    o_ctl.out_valid      = 1'b1;
                    o_ctl.out_from_stack = 1'b1;
                end
            end
            pqrs_pkg::CMD_SWAP: begin
                if (q_empty || s_empty) begin
                    o_ctl.status = pqrs_pkg::ST_EMPTY;
                end else begin
                    o_ctl.swap1 = i_go;
                end
            end
            pqrs_pkg::CMD_SWAP3: begin
                if (q_few || s_few) begin
                    o_ctl.status = pqrs_pkg::ST_TOO_FEW;
                end else begin
                    o_ctl.swap3 = i_go;
                end
            end
            default: begin
                o_ctl.status = pqrs_pkg::ST_DONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/pqrs_queue.sv */
// ----------------------------------------------------------------------------
// pqrs_queue
// Shifting queue: the front item always sits in entry zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pqrs_queue #(
    parameter int DEPTH     = 5,
    parameter int ITEM_BITS = 18
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire pqrs_pkg::t_ctl                               i_ctl,
    input  wire logic [ITEM_BITS-1:0]                         i_fresh,
    input  wire logic [pqrs_pkg::MULTI_SWAP-1:0][ITEM_BITS-1:0] i_swap_in,
    output logic [pqrs_pkg::MULTI_SWAP-1:0][ITEM_BITS-1:0]    o_front,
    output logic [$clog2(DEPTH+1)-1:0]                        o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int NS = pqrs_pkg::MULTI_SWAP;

    logic [DEPTH-1:0][ITEM_BITS-1:0] r_ent;
    logic [DEPTH-1:0][ITEM_BITS-1:0] n_ent;
    logic [DEPTH-1:0][ITEM_BITS-1:0] w_shift;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [CW-1:0]                   cnt_after;
    logic                            push_ok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_shift
        if (g < DEPTH - 1) begin : g_mid
            assign w_shift[g] = r_ent[g+1];
        end else begin : g_last
            assign w_shift[g] = r_ent[g];
        end
    end

    always_comb begin
        cnt_after = r_count - CW'(i_ctl.q_pop);
        push_ok   = i_ctl.q_push && (cnt_after < CW'(DEPTH));
        n_count   = cnt_after + CW'(push_ok);
        for (int i = 0; i < DEPTH; i++) begin
            n_ent[i] = i_ctl.q_pop ? w_shift[i] : r_ent[i];
            if (push_ok && (cnt_after == CW'(i))) begin
                n_ent[i] = i_fresh;
            end
        end
        if (i_ctl.swap1) begin
            n_ent[0] = i_swap_in[0];
        end
        if (i_ctl.swap3) begin
            for (int j = 0; j < NS; j++) begin
                n_ent[j] = i_swap_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_front = r_ent[NS-1:0];
    assign o_count = r_count;

endmodule

`default_nettype wire

/* hdl/pqrs_stack.sv */
// ----------------------------------------------------------------------------
// pqrs_stack
// Shifting stack: the top item always sits in entry zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pqrs_stack #(
    parameter int DEPTH     = 3,
    parameter int ITEM_BITS = 18
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire pqrs_pkg::t_ctl                               i_ctl,
    input  wire logic [ITEM_BITS-1:0]                         i_push_item,
    input  wire logic [pqrs_pkg::MULTI_SWAP-1:0][ITEM_BITS-1:0] i_swap_in,
    output logic [pqrs_pkg::MULTI_SWAP-1:0][ITEM_BITS-1:0]    o_top,
    output logic [$clog2(DEPTH+1)-1:0]                        o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int NS = pqrs_pkg::MULTI_SWAP;

    logic [DEPTH-1:0][ITEM_BITS-1:0] r_ent;
    logic [DEPTH-1:0][ITEM_BITS-1:0] n_ent;
    logic [DEPTH-1:0][ITEM_BITS-1:0] w_down;
    logic [DEPTH-1:0][ITEM_BITS-1:0] w_up;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;

    for (genvar g = 0; g < DEPTH; g++) begin : g_shift
        if (g == 0) begin : g_first
            assign w_down[g] = i_push_item;
        end else begin : g_rest
            assign w_down[g] = r_ent[g-1];
        end
        if (g < DEPTH - 1) begin : g_mid
            assign w_up[g] = r_ent[g+1];
        end else begin : g_last
            assign w_up[g] = r_ent[g];
        end
    end

    always_comb begin
        n_count = r_count + CW'(i_ctl.s_push) - CW'(i_ctl.s_pop);
        for (int i = 0; i < DEPTH; i++) begin
            n_ent[i] = r_ent[i];
            if (i_ctl.s_push) begin
                n_ent[i] = w_down[i];
            end else if (i_ctl.s_pop) begin
                n_ent[i] = w_up[i];
            end
        end
        if (i_ctl.swap1) begin
            n_ent[0] = i_swap_in[0];
        end
        if (i_ctl.swap3) begin
            for (int j = 0; j < NS; j++) begin
                n_ent[j] = i_swap_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_top   = r_ent[NS-1:0];
    assign o_count = r_count;

endmodule

`default_nettype wire
